// File: hw/rtl/vefc_pkg.sv
// ----------------------------------------------------------------------------
// vefc_pkg
// Shared types, codes and default sizes of the voxel exposed-face culler.
// ----------------------------------------------------------------------------
package vefc_pkg;

	// Default grid size along each axis
	localparam int GRID_X_DEF = 64;
	localparam int GRID_Y_DEF = 64;
	localparam int GRID_Z_DEF = 64;

	// Field widths
	localparam int CFG_W   = 7;   // extent register width
	localparam int CFG_IW  = 2;   // register index width
	localparam int VOX_W   = 8;   // voxel index width
	localparam int EXT_W   = 9;   // clamped extent width (holds up to 256)
	localparam int COLOR_W = 32;
	localparam int MASK_W  = 6;

	// Extent register reset value
	localparam logic [CFG_W-1:0] EXTENT_RST = 7'd64;

	// Register indexes
	localparam logic [CFG_IW-1:0] CFG_EXTENT_X = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_EXTENT_Y = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_EXTENT_Z = 2'd2;

	// Face mask bit positions
	localparam int FACE_PX = 0;
	localparam int FACE_MX = 1;
	localparam int FACE_PY = 2;
	localparam int FACE_MY = 3;
	localparam int FACE_PZ = 4;
	localparam int FACE_MZ = 5;

	// Request commands
	typedef enum logic [1:0] {
		CMD_MARK    = 2'd0,
		CMD_QUERY   = 2'd1,
		CMD_UNMARK  = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_C,
		ST_RD_PX,
		ST_RD_MX,
		ST_RD_PY,
		ST_RD_MY,
		ST_EVAL,
		ST_WRITE,
		ST_DONE
	} state_t;

	// Bounding box update request
	typedef struct packed {
		logic             mark;
		logic             restart;
		logic [VOX_W-1:0] x;
		logic [VOX_W-1:0] y;
		logic [VOX_W-1:0] z;
	} box_upd_t;

	// Bounding box status
	typedef struct packed {
		logic             seen;
		logic [VOX_W-1:0] min_x;
		logic [VOX_W-1:0] max_x;
		logic [VOX_W-1:0] min_y;
		logic [VOX_W-1:0] max_y;
		logic [VOX_W-1:0] min_z;
		logic [VOX_W-1:0] max_z;
	} box_stat_t;

endpackage

// File: hw/rtl/voxel_exposed_face_culler.sv
// ----------------------------------------------------------------------------
// voxel_exposed_face_culler
// Occupancy grid with six-neighbor exposed-face query and a bounding box.
// ----------------------------------------------------------------------------
// After reset the block sweeps the occupancy memory to zero, one row per
// cycle, over all GRID_X * GRID_Y rows (4096 at the default size); requests
// are held off during the sweep, while extent writes are taken. The grid is a
// single memory of GRID_X * GRID_Y rows of GRID_Z bits with one read port, so
// a query of a voxel inside the extents reads five rows in turn (own column,
// then +x, -x, +y, -y); mark and unmark inside the extents read and write back
// one row; every other request goes straight to its result with no memory
// access. A finished result sits in an output register, so one further
// request can be worked on while it waits to be taken.
// ----------------------------------------------------------------------------
module voxel_exposed_face_culler #(
	parameter int GRID_X = vefc_pkg::GRID_X_DEF,
	parameter int GRID_Y = vefc_pkg::GRID_Y_DEF,
	parameter int GRID_Z = vefc_pkg::GRID_Z_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration
	input  logic                         cfg_we,
	input  logic [vefc_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [vefc_pkg::CFG_W-1:0]   cfg_data,
	// Request channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   cmd,
	input  logic [vefc_pkg::VOX_W-1:0]   vox_x,
	input  logic [vefc_pkg::VOX_W-1:0]   vox_y,
	input  logic [vefc_pkg::VOX_W-1:0]   vox_z,
	input  logic [vefc_pkg::COLOR_W-1:0] voxel_color,
	// Result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [vefc_pkg::MASK_W-1:0]  face_mask,
	output logic                         inside_grid,
	output logic [vefc_pkg::COLOR_W-1:0] face_color,
	output logic                         box_valid,
	output logic [vefc_pkg::VOX_W-1:0]   box_min_x,
	output logic [vefc_pkg::VOX_W-1:0]   box_max_x,
	output logic [vefc_pkg::VOX_W-1:0]   box_min_y,
	output logic [vefc_pkg::VOX_W-1:0]   box_max_y,
	output logic [vefc_pkg::VOX_W-1:0]   box_min_z,
	output logic [vefc_pkg::VOX_W-1:0]   box_max_z
);

	localparam int DEPTH = GRID_X * GRID_Y;
	localparam int AW    = $clog2(DEPTH);
	localparam int ZW    = $clog2(GRID_Z);
	localparam int PW    = 2 * vefc_pkg::VOX_W + 1;  // row address product width
	localparam int EW    = vefc_pkg::EXT_W;
	localparam int VW    = vefc_pkg::VOX_W;

	localparam logic [EW-1:0] GX_E = EW'(GRID_X);
	localparam logic [EW-1:0] GY_E = EW'(GRID_Y);
	localparam logic [EW-1:0] GZ_E = EW'(GRID_Z);
	localparam logic [AW-1:0] ROW_LAST = AW'(DEPTH - 1);
	localparam logic [AW-1:0] Y_STRIDE = AW'(GRID_Y);

	vefc_pkg::state_t state_q, state_d;

	// Extent registers
	logic [vefc_pkg::CFG_W-1:0] ext_x_q, ext_y_q, ext_z_q;
	logic [EW-1:0]              ex, ey, ez;

	// Request registers
	vefc_pkg::cmd_t              cmd_q;
	logic [VW-1:0]               z_q;
	logic [vefc_pkg::COLOR_W-1:0] color_q;
	logic                        inside_q;
	logic                        px_edge_q, mx_edge_q, py_edge_q, my_edge_q;
	logic                        pz_edge_q, mz_edge_q;
	logic [AW-1:0]               row_q;
	logic [vefc_pkg::MASK_W-1:0] mask_q;
	logic [AW-1:0]               clr_q;

	// Output register
	logic                         out_valid_q;
	logic [vefc_pkg::MASK_W-1:0]  face_mask_q;
	logic                         inside_grid_q;
	logic [vefc_pkg::COLOR_W-1:0] face_color_q;
	vefc_pkg::box_stat_t          box_out_q;

	// Request decode
	logic          accept;
	logic          vox_in_ext;
	logic [EW-1:0] x_e, y_e, z_e;
	logic [PW-1:0] row_w;

	// Memory ports
	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_waddr, mem_raddr;
	logic [GRID_Z-1:0]     mem_wdata, mem_rdata;

	// Bit selects in the own column
	logic [VW-1:0] zp_w, zm_w;
	logic [ZW-1:0] z_idx, zp_idx, zm_idx;

	logic                 done;
	logic                 load_out;
	vefc_pkg::box_upd_t  box_upd;
	vefc_pkg::box_stat_t box_stat;

	// Clamp extents to the grid size
	assign ex = (EW'(ext_x_q) > GX_E) ? GX_E : EW'(ext_x_q);
	assign ey = (EW'(ext_y_q) > GY_E) ? GY_E : EW'(ext_y_q);
	assign ez = (EW'(ext_z_q) > GZ_E) ? GZ_E : EW'(ext_z_q);

	assign x_e        = EW'(vox_x);
	assign y_e        = EW'(vox_y);
	assign z_e        = EW'(vox_z);
	assign vox_in_ext = (x_e < ex) && (y_e < ey) && (z_e < ez);
	assign row_w      = PW'(vox_x) * PW'(GRID_Y) + PW'(vox_y);

	assign in_ready = (state_q == vefc_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Write extent registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_x_q <= vefc_pkg::EXTENT_RST;
			ext_y_q <= vefc_pkg::EXTENT_RST;
			ext_z_q <= vefc_pkg::EXTENT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vefc_pkg::CFG_EXTENT_X: ext_x_q <= cfg_data;
				vefc_pkg::CFG_EXTENT_Y: ext_y_q <= cfg_data;
				vefc_pkg::CFG_EXTENT_Z: ext_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Own-column bit positions
	assign zp_w   = z_q + VW'(1);
	assign zm_w   = z_q - VW'(1);
	assign z_idx  = z_q[ZW-1:0];
	assign zp_idx = zp_w[ZW-1:0];
	assign zm_idx = zm_w[ZW-1:0];

	// Capture the request and its neighbor edges
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= vefc_pkg::cmd_t'(cmd);
			z_q       <= vox_z;
			color_q   <= voxel_color;
			inside_q  <= vox_in_ext;
			row_q     <= row_w[AW-1:0];
			px_edge_q <= (x_e + EW'(1)) >= ex;
			mx_edge_q <= (vox_x == '0);
			py_edge_q <= (y_e + EW'(1)) >= ey;
			my_edge_q <= (vox_y == '0);
			pz_edge_q <= (z_e + EW'(1)) >= ez;
			mz_edge_q <= (vox_z == '0);
		end
	end

	// Build the face mask as neighbor rows come back
	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q <= '0;
		end else begin
			case (state_q)
				vefc_pkg::ST_RD_PX: begin
					mask_q[vefc_pkg::FACE_PZ] <= pz_edge_q || !mem_rdata[zp_idx];
					mask_q[vefc_pkg::FACE_MZ] <= mz_edge_q || !mem_rdata[zm_idx];
				end
				vefc_pkg::ST_RD_MX: mask_q[vefc_pkg::FACE_PX] <= px_edge_q || !mem_rdata[z_idx];
				vefc_pkg::ST_RD_PY: mask_q[vefc_pkg::FACE_MX] <= mx_edge_q || !mem_rdata[z_idx];
				vefc_pkg::ST_RD_MY: mask_q[vefc_pkg::FACE_PY] <= py_edge_q || !mem_rdata[z_idx];
				vefc_pkg::ST_EVAL:  mask_q[vefc_pkg::FACE_MY] <= my_edge_q || !mem_rdata[z_idx];
				default: ;
			endcase
		end
	end

	// Advance the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == vefc_pkg::ST_CLEAR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vefc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign done     = (state_q == vefc_pkg::ST_DONE);
	assign load_out = done && (!out_valid_q || out_ready);

	// Next state and memory access; neighbors past an extent read the own row
	always_comb begin
		state_d   = state_q;
		mem_re    = 1'b0;
		mem_raddr = row_q;
		mem_we    = 1'b0;
		mem_waddr = row_q;
		mem_wdata = mem_rdata;
		unique case (state_q)
			vefc_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == ROW_LAST) state_d = vefc_pkg::ST_IDLE;
			end
			vefc_pkg::ST_IDLE: begin
				if (accept) begin
					if (vox_in_ext && vefc_pkg::cmd_t'(cmd) != vefc_pkg::CMD_RESTART) begin
						state_d = vefc_pkg::ST_RD_C;
					end else begin
						state_d = vefc_pkg::ST_DONE;
					end
				end
			end
			vefc_pkg::ST_RD_C: begin
				mem_re = 1'b1;
				if (cmd_q == vefc_pkg::CMD_QUERY) begin
					state_d = vefc_pkg::ST_RD_PX;
				end else begin
					state_d = vefc_pkg::ST_WRITE;
				end
			end
			vefc_pkg::ST_RD_PX: begin
				mem_re = 1'b1;
				if (!px_edge_q) mem_raddr = row_q + Y_STRIDE;
				state_d = vefc_pkg::ST_RD_MX;
			end
			vefc_pkg::ST_RD_MX: begin
				mem_re = 1'b1;
				if (!mx_edge_q) mem_raddr = row_q - Y_STRIDE;
				state_d = vefc_pkg::ST_RD_PY;
			end
			vefc_pkg::ST_RD_PY: begin
				mem_re = 1'b1;
				if (!py_edge_q) mem_raddr = row_q + AW'(1);
				state_d = vefc_pkg::ST_RD_MY;
			end
			vefc_pkg::ST_RD_MY: begin
				mem_re = 1'b1;
				if (!my_edge_q) mem_raddr = row_q - AW'(1);
				state_d = vefc_pkg::ST_EVAL;
			end
			vefc_pkg::ST_EVAL: begin
				state_d = vefc_pkg::ST_DONE;
			end
			vefc_pkg::ST_WRITE: begin
				mem_we           = 1'b1;
				mem_wdata[z_idx] = (cmd_q == vefc_pkg::CMD_MARK);
				state_d          = vefc_pkg::ST_DONE;
			end
			vefc_pkg::ST_DONE: begin
				if (load_out) state_d = vefc_pkg::ST_IDLE;
			end
			default: state_d = vefc_pkg::ST_IDLE;
		endcase
	end

	// Box update on accepted mark and restart requests
	assign box_upd.mark    = accept && (vefc_pkg::cmd_t'(cmd) == vefc_pkg::CMD_MARK);
	assign box_upd.restart = accept && (vefc_pkg::cmd_t'(cmd) == vefc_pkg::CMD_RESTART);
	assign box_upd.x       = vox_x;
	assign box_upd.y       = vox_y;
	assign box_upd.z       = vox_z;

	vefc_bbox u_bbox (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (box_upd),
		.stat   (box_stat)
	);

	vefc_grid_mem #(
		.DEPTH (DEPTH),
		.WIDTH (GRID_Z)
	) u_grid_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			face_mask_q   <= (cmd_q == vefc_pkg::CMD_QUERY) ? mask_q : '0;
			inside_grid_q <= inside_q;
			face_color_q  <= (cmd_q == vefc_pkg::CMD_QUERY) ? color_q : '0;
			box_out_q     <= box_stat;
		end
	end

	assign out_valid   = out_valid_q;
	assign face_mask   = face_mask_q;
	assign inside_grid = inside_grid_q;
	assign face_color  = face_color_q;
	assign box_valid   = box_out_q.seen;
	assign box_min_x   = box_out_q.min_x;
	assign box_max_x   = box_out_q.max_x;
	assign box_min_y   = box_out_q.min_y;
	assign box_max_y   = box_out_q.max_y;
	assign box_min_z   = box_out_q.min_z;
	assign box_max_z   = box_out_q.max_z;

endmodule

// File: hw/rtl/vefc_grid_mem.sv
// ----------------------------------------------------------------------------
// vefc_grid_mem
// Occupancy memory: one row holds all z bits of one (x, y) column.
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vefc_grid_mem #(
	parameter int DEPTH = vefc_pkg::GRID_X_DEF * vefc_pkg::GRID_Y_DEF,
	parameter int WIDTH = vefc_pkg::GRID_Z_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write row
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read row into the registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/vefc_bbox.sv
// ----------------------------------------------------------------------------
// vefc_bbox
// Running bounding box of marked voxel indices.
// ----------------------------------------------------------------------------
module vefc_bbox (
	input  logic                clk,
	input  logic                arst_n,
	input  vefc_pkg::box_upd_t  upd,
	output vefc_pkg::box_stat_t stat
);

	vefc_pkg::box_stat_t box_q;

	// Start, widen or empty the box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '0;
		end else if (upd.restart) begin
			box_q <= '0;
		end else if (upd.mark) begin
			box_q.seen <= 1'b1;
			if (!box_q.seen) begin
				box_q.min_x <= upd.x;
				box_q.max_x <= upd.x;
				box_q.min_y <= upd.y;
				box_q.max_y <= upd.y;
				box_q.min_z <= upd.z;
				box_q.max_z <= upd.z;
			end else begin
				if (upd.x < box_q.min_x) box_q.min_x <= upd.x;
				if (upd.x > box_q.max_x) box_q.max_x <= upd.x;
				if (upd.y < box_q.min_y) box_q.min_y <= upd.y;
				if (upd.y > box_q.max_y) box_q.max_y <= upd.y;
				if (upd.z < box_q.min_z) box_q.min_z <= upd.z;
				if (upd.z > box_q.max_z) box_q.max_z <= upd.z;
			end
		end
	end

	assign stat = box_q;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the voxel exposed-face culler.
// ----------------------------------------------------------------------------
// Sends mark, query, unmark and restart requests over the valid/ready request
// channel. A local copy of the occupancy grid, the bounding box and the extent
// registers predicts every result, and each result field is compared with it.
// The directed cases cover grid corners, covered and open neighbor faces,
// voxels outside the extents, a restart of the box, and extent settings of
// zero, saturation, shrink and regrow. The random traffic runs clustered
// voxels under a series of extent settings. Bursty sending and a stall pattern
// on the result side run through the whole test.
// ----------------------------------------------------------------------------
module tb;
	import vefc_pkg::*;

	localparam int NX = GRID_X_DEF;
	localparam int NY = GRID_Y_DEF;
	localparam int NZ = GRID_Z_DEF;

	typedef struct packed {
		logic [MASK_W-1:0]  mask;
		logic               in_grid;
		logic [COLOR_W-1:0] color;
		logic               seen;
		logic [VOX_W-1:0]   min_x, max_x, min_y, max_y, min_z, max_z;
	} face_result_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_we      = 1'b0;
	logic [CFG_IW-1:0]  cfg_index   = '0;
	logic [CFG_W-1:0]   cfg_data    = '0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [1:0]         cmd         = '0;
	logic [VOX_W-1:0]   vox_x       = '0;
	logic [VOX_W-1:0]   vox_y       = '0;
	logic [VOX_W-1:0]   vox_z       = '0;
	logic [COLOR_W-1:0] voxel_color = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [MASK_W-1:0]  face_mask;
	logic               inside_grid;
	logic [COLOR_W-1:0] face_color;
	logic               box_valid;
	logic [VOX_W-1:0]   box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z;

	// Mirror of the block state
	bit                 occ_grid [0:NX-1][0:NY-1][0:NZ-1];
	logic               box_seen_m = 1'b0;
	logic [VOX_W-1:0]   box_lo [0:2] = '{8'd0, 8'd0, 8'd0};
	logic [VOX_W-1:0]   box_hi [0:2] = '{8'd0, 8'd0, 8'd0};
	logic [CFG_W-1:0]   ext_reg [0:2] = '{EXTENT_RST, EXTENT_RST, EXTENT_RST};

	face_result_t       expected_faces [$];
	int                 errors = 0;
	int                 sent = 0;
	int                 checked = 0;
	int                 queries = 0;
	int                 covered_queries = 0;
	int                 settings_used = 0;
	int                 burst_left = 0;
	logic [9:0]         stall_cycle = '0;

	voxel_exposed_face_culler uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.vox_x       (vox_x),
		.vox_y       (vox_y),
		.vox_z       (vox_z),
		.voxel_color (voxel_color),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.face_mask   (face_mask),
		.inside_grid (inside_grid),
		.face_color  (face_color),
		.box_valid   (box_valid),
		.box_min_x   (box_min_x),
		.box_max_x   (box_max_x),
		.box_min_y   (box_min_y),
		.box_max_y   (box_max_y),
		.box_min_z   (box_min_z),
		.box_max_z   (box_max_z)
	);

	always #6 clk = ~clk;

	// Extent in use on one axis: register value saturated to the grid size
	function automatic int extent_in_use(input int axis);
		int limit;
		limit = (axis == 0) ? NX : (axis == 1) ? NY : NZ;
		return (ext_reg[axis] > limit) ? limit : int'(ext_reg[axis]);
	endfunction

	// Apply one request to the mirrored state and build its result
	function automatic face_result_t apply_request(input cmd_t op,
			input logic [VOX_W-1:0] x, y, z, input logic [COLOR_W-1:0] color);
		face_result_t res;
		int c [0:2];
		int lim [0:2];
		logic in_ext;
		int a;
		c[0] = int'(x);
		c[1] = int'(y);
		c[2] = int'(z);
		for (a = 0; a < 3; a++)
			lim[a] = extent_in_use(a);
		in_ext = (c[0] < lim[0]) && (c[1] < lim[1]) && (c[2] < lim[2]);
		res = '0;
		res.in_grid = in_ext;
		case (op)
		CMD_MARK: begin
			if (in_ext)
				occ_grid[c[0]][c[1]][c[2]] = 1'b1;
			// first voxel after reset or restart sets the box outright
			for (a = 0; a < 3; a++) begin
				if (!box_seen_m || c[a] < box_lo[a])
					box_lo[a] = VOX_W'(c[a]);
				if (!box_seen_m || c[a] > box_hi[a])
					box_hi[a] = VOX_W'(c[a]);
			end
			box_seen_m = 1'b1;
		end
		CMD_QUERY: begin
			res.color = color;
			// a face is open at the extent edge or next to an empty cell
			if (in_ext) begin
				res.mask[FACE_PX] = (c[0] + 1 >= lim[0]) || !occ_grid[c[0] + 1][c[1]][c[2]];
				res.mask[FACE_MX] = (c[0] == 0) || !occ_grid[c[0] - 1][c[1]][c[2]];
				res.mask[FACE_PY] = (c[1] + 1 >= lim[1]) || !occ_grid[c[0]][c[1] + 1][c[2]];
				res.mask[FACE_MY] = (c[1] == 0) || !occ_grid[c[0]][c[1] - 1][c[2]];
				res.mask[FACE_PZ] = (c[2] + 1 >= lim[2]) || !occ_grid[c[0]][c[1]][c[2] + 1];
				res.mask[FACE_MZ] = (c[2] == 0) || !occ_grid[c[0]][c[1]][c[2] - 1];
			end
		end
		CMD_UNMARK: begin
			if (in_ext)
				occ_grid[c[0]][c[1]][c[2]] = 1'b0;
		end
		default: begin
			box_seen_m = 1'b0;
			for (a = 0; a < 3; a++) begin
				box_lo[a] = '0;
				box_hi[a] = '0;
			end
		end
		endcase
		res.seen  = box_seen_m;
		res.min_x = box_lo[0];
		res.max_x = box_hi[0];
		res.min_y = box_lo[1];
		res.max_y = box_hi[1];
		res.min_z = box_lo[2];
		res.max_z = box_hi[2];
		return res;
	endfunction

	// Send one request, record its result, then rest when the burst runs out
	task automatic send_voxel(input cmd_t op, input logic [VOX_W-1:0] x, y, z,
			input logic [COLOR_W-1:0] color);
		face_result_t res;
		in_valid    <= 1'b1;
		cmd         <= op;
		vox_x       <= x;
		vox_y       <= y;
		vox_z       <= z;
		voxel_color <= color;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		res = apply_request(op, x, y, z, color);
		expected_faces.push_back(res);
		sent++;
		if (op == CMD_QUERY) begin
			queries++;
			if (res.in_grid && res.mask != 6'h3F)
				covered_queries++;
		end
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(40, 80)) :
				int'($urandom_range(1, 16));
		end
	endtask

	// Hold off new requests until every result is back and the block settles
	task automatic wait_idle;
		in_valid <= 1'b0;
		while (expected_faces.size() != 0)
			@(posedge clk);
		repeat (12)
			@(posedge clk);
	endtask

	// Write all three extent registers while the block is idle
	task automatic set_extents(input logic [CFG_W-1:0] ex, ey, ez);
		logic [CFG_W-1:0] vals [0:2];
		logic [CFG_IW-1:0] regs [0:2];
		int a;
		vals = '{ex, ey, ez};
		regs = '{CFG_EXTENT_X, CFG_EXTENT_Y, CFG_EXTENT_Z};
		wait_idle();
		for (a = 0; a < 3; a++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[a];
			cfg_data  <= vals[a];
			@(posedge clk);
			ext_reg[a] = vals[a];
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Cluster around a base, sometimes near the edge, sometimes anywhere
	function automatic logic [VOX_W-1:0] pick_coord(input int lim, input int base);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 85)
			return VOX_W'(base + int'($urandom_range(0, 3)));
		if (roll < 95)
			return VOX_W'($urandom_range(0, lim));
		return VOX_W'($urandom_range(0, 255));
	endfunction

	task automatic test_face_exposure;
		set_extents(7'd64, 7'd64, 7'd64);
		send_voxel(CMD_QUERY, 8'd0, 8'd0, 8'd0, 32'h0000_0000);
		send_voxel(CMD_MARK, 8'd5, 8'd5, 8'd5, $urandom);
		send_voxel(CMD_MARK, 8'd6, 8'd5, 8'd5, $urandom);
		send_voxel(CMD_MARK, 8'd4, 8'd5, 8'd5, $urandom);
		send_voxel(CMD_MARK, 8'd5, 8'd6, 8'd5, $urandom);
		send_voxel(CMD_MARK, 8'd5, 8'd4, 8'd5, $urandom);
		send_voxel(CMD_MARK, 8'd5, 8'd5, 8'd6, $urandom);
		send_voxel(CMD_MARK, 8'd5, 8'd5, 8'd4, $urandom);
		// fully enclosed, then open one side
		send_voxel(CMD_QUERY, 8'd5, 8'd5, 8'd5, 32'hFFFF_FFFF);
		send_voxel(CMD_UNMARK, 8'd6, 8'd5, 8'd5, $urandom);
		send_voxel(CMD_QUERY, 8'd5, 8'd5, 8'd5, $urandom);
		send_voxel(CMD_QUERY, 8'd63, 8'd63, 8'd63, $urandom);
	endtask

	task automatic test_bounding_box;
		// outside voxel still widens the box
		send_voxel(CMD_MARK, 8'd255, 8'd255, 8'd255, $urandom);
		send_voxel(CMD_QUERY, 8'd255, 8'd0, 8'd64, $urandom);
		send_voxel(CMD_UNMARK, 8'd64, 8'd0, 8'd0, $urandom);
		send_voxel(CMD_RESTART, 8'd17, 8'd200, 8'd3, $urandom);
		send_voxel(CMD_MARK, 8'd0, 8'd0, 8'd0, $urandom);
		send_voxel(CMD_QUERY, 8'd0, 8'd0, 8'd0, $urandom);
	endtask

	task automatic test_extent_settings;
		send_voxel(CMD_MARK, 8'd6, 8'd5, 8'd5, $urandom);
		// shrink x: the marked neighbor drops out of view
		set_extents(7'd6, 7'd64, 7'd64);
		send_voxel(CMD_QUERY, 8'd5, 8'd5, 8'd5, $urandom);
		send_voxel(CMD_QUERY, 8'd6, 8'd5, 8'd5, $urandom);
		// regrow: it comes back
		set_extents(7'd64, 7'd64, 7'd64);
		send_voxel(CMD_QUERY, 8'd5, 8'd5, 8'd5, $urandom);
		set_extents(7'd0, 7'd0, 7'd0);
		send_voxel(CMD_QUERY, 8'd0, 8'd0, 8'd0, $urandom);
		send_voxel(CMD_MARK, 8'd0, 8'd0, 8'd0, $urandom);
		// saturated extents
		set_extents(7'd127, 7'd127, 7'd127);
		send_voxel(CMD_QUERY, 8'd63, 8'd5, 8'd5, $urandom);
	endtask

	task automatic test_random_traffic;
		int ext [0:2];
		int base [0:2];
		int p, n, a, lim, roll;
		cmd_t op;
		logic [VOX_W-1:0] v [0:2];
		for (p = 0; p < 10; p++) begin
			case (p)
			0: ext = '{64, 64, 64};
			1: ext = '{4, 4, 4};
			2: ext = '{1, 1, 1};
			3: ext = '{127, 127, 127};
			4: ext = '{0, 64, 64};
			5: ext = '{64, 0, 5};
			6: ext = '{2, 64, 3};
			9: ext = '{64, 64, 64};
			default: begin
				for (a = 0; a < 3; a++)
					ext[a] = $urandom_range(1, 70);
			end
			endcase
			set_extents(CFG_W'(ext[0]), CFG_W'(ext[1]), CFG_W'(ext[2]));
			// pick a small cluster, often against one edge of the extents
			for (a = 0; a < 3; a++) begin
				lim = extent_in_use(a);
				roll = $urandom_range(0, 3);
				if (lim <= 4 || roll == 0)
					base[a] = 0;
				else if (roll == 1)
					base[a] = lim - 4;
				else
					base[a] = $urandom_range(0, lim - 4);
			end
			for (n = 0; n < 115; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 42)
					op = CMD_MARK;
				else if (roll < 77)
					op = CMD_QUERY;
				else if (roll < 96)
					op = CMD_UNMARK;
				else
					op = CMD_RESTART;
				for (a = 0; a < 3; a++)
					v[a] = pick_coord(extent_in_use(a), base[a]);
				send_voxel(op, v[0], v[1], v[2], $urandom);
			end
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] want, got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Compare each taken result with the oldest prediction
	always @(posedge clk) begin : take_result
		face_result_t want;
		if (out_valid && out_ready) begin
			if (expected_faces.size() == 0) begin
				$display("%0t: result with no request outstanding", $time);
				errors++;
			end else begin
				want = expected_faces.pop_front();
				check_field("face_mask", 32'(want.mask), 32'(face_mask));
				check_field("inside_grid", 32'(want.in_grid), 32'(inside_grid));
				check_field("face_color", want.color, face_color);
				check_field("box_valid", 32'(want.seen), 32'(box_valid));
				check_field("box_min_x", 32'(want.min_x), 32'(box_min_x));
				check_field("box_max_x", 32'(want.max_x), 32'(box_max_x));
				check_field("box_min_y", 32'(want.min_y), 32'(box_min_y));
				check_field("box_max_y", 32'(want.max_y), 32'(box_max_y));
				check_field("box_min_z", 32'(want.min_z), 32'(box_min_z));
				check_field("box_max_z", 32'(want.max_z), 32'(box_max_z));
				checked++;
			end
		end
	end

	// Result-side stalls: steady, light random, long, heavy random
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 10'd1;
		case (stall_cycle[9:8])
		2'd0: out_ready <= 1'b1;
		2'd1: out_ready <= ($urandom_range(0, 2) != 0);
		2'd2: out_ready <= (stall_cycle[2:0] == 3'd0);
		default: out_ready <= 1'($urandom_range(0, 1));
		endcase
	end

	initial begin
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		test_face_exposure();
		test_bounding_box();
		test_extent_settings();
		test_random_traffic();
		wait_idle();
		$display("summary: %0d requests, %0d queries (%0d with a covered face), %0d results",
			sent, queries, covered_queries, checked);
		$display("summary: %0d extent settings, including zero and saturated", settings_used);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// Abort a hung run
	initial begin
		#5_000_000;
		$display("tb: errors");
		$finish;
	end

endmodule
